>>> src/dvc_pkg.sv
// Package for the distinct value counter: field widths, limits, command,
// result and state types. No dependencies.
package dvc_pkg;

    localparam int VALUE_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int INDEX_W    = 5;
    localparam int TOTAL_W    = 6;
    localparam int MEAN_W     = 14;
    localparam int SUM_W      = 16;
    localparam int LOCI_W     = 11;
    localparam int DIVIDEND_W = SUM_W + 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 16'd65535;
    localparam logic [LOCI_W-1:0]  LOCI_MAX  = 11'd2047;
    localparam logic [MEAN_W-1:0]  MEAN_MAX  = 14'd16383;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_COPY,
        KIND_LOCUS,
        KIND_SAMPLE
    } t_kind;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_kind              kind;
    } t_cmd;

    typedef struct packed {
        logic [MEAN_W-1:0]  mean;
        logic               ovf;
        logic               poly;
        logic [TOTAL_W-1:0] total;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] value;
        logic               is_mean;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_EMIT,
        ST_DIV,
        ST_MEAN
    } t_state;

endpackage

>>> src/dvc_front.sv
// Front end: accepts gene copies, classifies them and queues commands.
// Depends on dvc_pkg.
module dvc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [9:0]    i_value,
    input  logic          i_locus_end,
    input  logic          i_sample_end,
    output logic          o_cmd_valid,
    output dvc_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import dvc_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              cmd_in;
    logic              push, pop;

    always_comb begin
        cmd_in.value = i_value;
        priority if (i_locus_end && i_sample_end) begin
            cmd_in.kind = KIND_SAMPLE;
        end else if (i_locus_end) begin
            cmd_in.kind = KIND_LOCUS;
        end else begin
            cmd_in.kind = KIND_COPY;
        end
    end

    assign o_ready     = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_slot[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= cmd_in;
        end
    end

endmodule

>>> src/dvc_div.sv
// Restoring divider, one quotient bit per cycle, for the per-sample mean.
// Depends on dvc_pkg.
module dvc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [dvc_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [dvc_pkg::LOCI_W-1:0]       i_divisor,
    output logic                             o_busy,
    output logic [dvc_pkg::DIVIDEND_W-1:0]   o_quotient
);
    import dvc_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic [STEP_W-1:0]     r_step;
    logic [LOCI_W-1:0]     r_rem;
    logic [LOCI_W-1:0]     r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [LOCI_W:0]       trial, diff;
    logic                  ge;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[LOCI_W-1:0] : trial[LOCI_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

>>> src/dvc_back.sv
// Back end: table search and update, per-locus emission and sample mean.
// Depends on dvc_pkg and dvc_div.
module dvc_back #(
    parameter int MAX_ALLELES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  dvc_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dvc_pkg::t_result o_out
);
    import dvc_pkg::*;

    localparam int AW = $clog2(MAX_ALLELES);
    localparam int UW = $clog2(MAX_ALLELES + 1);

    logic [VALUE_W-1:0] r_value_mem [MAX_ALLELES];
    logic [COUNT_W-1:0] r_count_mem [MAX_ALLELES];
    logic [VALUE_W-1:0] r_rd_value;
    logic [COUNT_W-1:0] r_rd_count;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [UW-1:0]      r_used, n_used;
    logic               r_ovf, n_ovf;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [LOCI_W-1:0]  r_loci, n_loci;
    logic [VALUE_W-1:0] r_value, n_value;
    t_kind              r_kind, n_kind;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [AW-1:0]      rd_addr, waddr;
    logic               we;
    logic [VALUE_W-1:0] wvalue;
    logic [COUNT_W-1:0] wcount;
    logic               out_free, hit, at_end, full;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_close;
    logic [LOCI_W-1:0]  loci_close;
    logic [7:0]         ptr_wide;
    logic [8:0]         used_wide;
    logic               div_start, div_busy;
    logic [DIVIDEND_W-1:0] quotient;
    logic [MEAN_W-1:0]  mean_sat;

    dvc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({sum_close, 8'h00}),
        .i_divisor  (loci_close),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign hit        = r_rd_value == r_value;
    assign at_end     = (UW'(r_ptr) + UW'(1)) == r_used;
    assign full       = r_used == UW'(MAX_ALLELES);
    assign sum_add    = {1'b0, r_sum} + (SUM_W + 1)'(r_used);
    assign sum_close  = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
    assign loci_close = (r_loci < LOCI_MAX) ? r_loci + 1'b1 : r_loci;
    assign ptr_wide   = 8'(r_ptr);
    assign used_wide  = 9'(r_used);
    assign mean_sat   = (quotient > DIVIDEND_W'(MEAN_MAX)) ? MEAN_MAX
                                                            : quotient[MEAN_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_used      = r_used;
        n_ovf       = r_ovf;
        n_sum       = r_sum;
        n_loci      = r_loci;
        n_value     = r_value;
        n_kind      = r_kind;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_addr     = r_ptr;
        we          = 1'b0;
        waddr       = r_ptr;
        wvalue      = r_value;
        wcount      = COUNT_W'(1);
        o_cmd_pop   = 1'b0;
        div_start   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_value   = i_cmd.value;
                    n_kind    = i_cmd.kind;
                    n_ptr     = '0;
                    rd_addr   = '0;
                    if (r_used == '0) begin
                        we      = 1'b1;
                        waddr   = '0;
                        wvalue  = i_cmd.value;
                        n_used  = UW'(1);
                        n_state = ST_CHECK;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (hit) begin
                    we      = 1'b1;
                    wcount  = (r_rd_count < COUNT_MAX) ? r_rd_count + 1'b1 : r_rd_count;
                    n_state = ST_CHECK;
                end else if (at_end) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        we     = 1'b1;
                        waddr  = r_used[AW-1:0];
                        n_used = r_used + 1'b1;
                    end
                    n_state = ST_CHECK;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    rd_addr = r_ptr + 1'b1;
                end
            end
            ST_CHECK: begin
                n_ptr   = '0;
                rd_addr = '0;
                n_state = (r_kind == KIND_COPY) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.value   = r_rd_value;
                    n_out.count   = r_rd_count;
                    n_out.index   = ptr_wide[INDEX_W-1:0];
                    n_out.total   = used_wide[TOTAL_W-1:0];
                    n_out.poly    = r_used > UW'(1);
                    n_out.ovf     = r_ovf;
                    n_out.mean    = '0;
                    n_out.is_mean = 1'b0;
                    n_out.last    = at_end && (r_kind != KIND_SAMPLE);
                    if (at_end) begin
                        n_sum  = sum_close;
                        n_loci = loci_close;
                        n_used = '0;
                        n_ovf  = 1'b0;
                        if (r_kind == KIND_SAMPLE) begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_ptr   = r_ptr + 1'b1;
                        rd_addr = r_ptr + 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out         = '0;
                    n_out.mean    = mean_sat;
                    n_out.is_mean = 1'b1;
                    n_out.last    = 1'b1;
                    n_sum         = '0;
                    n_loci        = '0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_used      <= '0;
            r_ovf       <= 1'b0;
            r_sum       <= '0;
            r_loci      <= '0;
            r_kind      <= KIND_COPY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_used      <= n_used;
            r_ovf       <= n_ovf;
            r_sum       <= n_sum;
            r_loci      <= n_loci;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_value_mem[waddr] <= wvalue;
            r_count_mem[waddr] <= wcount;
        end
        r_rd_value <= r_value_mem[rd_addr];
        r_rd_count <= r_count_mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_ALLELES))
        else $error("table use count beyond capacity");

    a_ptr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH || r_state == ST_EMIT) |-> (UW'(r_ptr) < r_used))
        else $error("scan pointer outside used entries");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_mean_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MEAN) |-> !div_busy)
        else $error("mean taken before division finished");
`endif

endmodule

>>> src/distinct_value_counter.sv
// Distinct value counter top level: front queue, table engine, mean divider.
// Depends on dvc_pkg, dvc_front, dvc_back, dvc_div.
//
// Gene copies stream in one per transfer; each is matched against the locus
// table by a scan of one entry per cycle through the table memory. A copy
// that ends a locus then emits one result per used entry, one per cycle
// while the output is taken, and clears the table. A copy that also ends a
// sample then runs the serial division (24 quotient steps) and emits one
// mean result (Q.8, saturated). A two-deep command queue lets input
// transfers continue while results are emitted.
module distinct_value_counter #(
    parameter int MAX_ALLELES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] allele_value
    input  logic        s_axis_tlast,   // locus_end
    input  logic        s_axis_tuser,   // sample_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // entry_value, entry_count, entry_index,
                                        // distinct_total, polymorphic,
                                        // table_overflow, mean_distinct
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser    // is_mean
);
    import dvc_pkg::*;

    logic    cmd_valid, cmd_pop;
    t_cmd    cmd;
    t_result res;

    dvc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_value      (s_axis_tdata[9:0]),
        .i_locus_end  (s_axis_tlast),
        .i_sample_end (s_axis_tuser),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    dvc_back #(
        .MAX_ALLELES (MAX_ALLELES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tdata = {res.mean, res.ovf, res.poly, res.total,
                           res.index, res.count, res.value};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.is_mean;

endmodule
